@@ rtl/tilt_complementary_filter_pd_macros.svh @@
// Assertion macros used by the tilt filter sequencer.
// Each check samples on aclk and is held off while aresetn is low.
`ifndef TILT_COMPLEMENTARY_FILTER_PD_MACROS_SVH
`define TILT_COMPLEMENTARY_FILTER_PD_MACROS_SVH
`ifndef SYNTH
`define TCFPD_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("tcfpd check failed");
`define TCFPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tcfpd implication failed");
`define TCFPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tcfpd next-cycle check failed");
`else
`define TCFPD_ASSERT(lbl, expr)
`define TCFPD_ASSERT_IMP(lbl, ante, cons)
`define TCFPD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/tcfpd_pkg.sv @@
// Shared types, constants and the control program of the tilt filter.
// Used by the config, sequencer, datapath and top-level modules.
package tcfpd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int DELTA_W     = SAMPLE_BITS + 1;
    localparam int GAIN_W      = 16;
    localparam int DATA_W      = 16;
    localparam int LIMIT_W     = 15;
    localparam int ACC_W       = 32;
    localparam int ANGLE_SHIFT = 5;

    localparam int S_FIELDS_W = 2 * SAMPLE_BITS + DATA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 3 * DATA_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int PC_W      = 5;
    localparam int UCODE_LEN = 28;

    // Reciprocal constants: floor(m / C) is (m * R) >> S or one less, for m < 2**32
    localparam int          DIV100_SHIFT  = 38;
    localparam int          DIV1000_SHIFT = 41;
    localparam logic [31:0] DIV100_RECIP  = 32'd2748779069;
    localparam logic [31:0] DIV1000_RECIP = 32'd2199023255;
    localparam int          REM_W         = 11;

    localparam logic signed [DATA_W:0] DRV_MAX = 17'sd32767;
    localparam logic signed [DATA_W:0] DRV_MIN = -17'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_ZERO  = 4'd0,
        REG_GYRO_ZERO   = 4'd1,
        REG_ACCEL_SCALE = 4'd2,
        REG_GYRO_SCALE  = 4'd3,
        REG_CORR_GAIN   = 4'd4,
        REG_P_GAIN      = 4'd5,
        REG_D_GAIN      = 4'd6,
        REG_DRIVE_LIMIT = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] accel_zero;
        logic [SAMPLE_BITS-1:0] gyro_zero;
        logic [GAIN_W-1:0]      accel_scale;
        logic [GAIN_W-1:0]      gyro_scale;
        logic [GAIN_W-1:0]      corr_gain;
        logic [GAIN_W-1:0]      p_gain;
        logic [GAIN_W-1:0]      d_gain;
        logic [LIMIT_W-1:0]     drive_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        accel_zero:  SAMPLE_BITS'(2048),
        gyro_zero:   SAMPLE_BITS'(2048),
        accel_scale: GAIN_W'(100),
        gyro_scale:  GAIN_W'(100),
        corr_gain:   '0,
        p_gain:      '0,
        d_gain:      '0,
        drive_limit: LIMIT_W'(32767)
    };

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_ACCEL,
        OP_MUL_GYRO,
        OP_MUL_ERR,
        OP_MUL_ANG_P,
        OP_MUL_RATE_D,
        OP_SUM_SET,
        OP_SUM_ADD,
        OP_SUM_ABS,
        OP_RECIP,
        OP_QEST,
        OP_REM,
        OP_FIX,
        OP_CLAMP,
        OP_DRIVE,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        DST_ACCEL,
        DST_RATE,
        DST_FB,
        DST_PD
    } dst_t;

    typedef enum logic {
        DIV_100,
        DIV_1000
    } div_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_WAIT_OUT,
        JMP_GOTO
    } jmp_t;

    typedef struct packed {
        op_t             op;
        dst_t            dst;
        div_t            dv;
        jmp_t            jmp;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } stat_t;

    function automatic logic [REM_W-1:0] div_const(input div_t dv);
        return (dv == DIV_1000) ? REM_W'(1000) : REM_W'(100);
    endfunction

    function automatic ctrl_t cw(input op_t op, input dst_t dst, input div_t dv,
                                 input jmp_t jmp, input logic [PC_W-1:0] target);
        ctrl_t w;
        w.op     = op;
        w.dst    = dst;
        w.dv     = dv;
        w.jmp    = jmp;
        w.target = target;
        return w;
    endfunction

    // Control store: one word per step
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            5'd0:    w = cw(OP_LOAD,       DST_ACCEL, DIV_100,  JMP_WAIT_IN,  '0);
            // accel normalise
            5'd1:    w = cw(OP_MUL_ACCEL,  DST_ACCEL, DIV_100,  JMP_NEXT,     '0);
            5'd2:    w = cw(OP_RECIP,      DST_ACCEL, DIV_100,  JMP_NEXT,     '0);
            5'd3:    w = cw(OP_QEST,       DST_ACCEL, DIV_100,  JMP_NEXT,     '0);
            5'd4:    w = cw(OP_REM,        DST_ACCEL, DIV_100,  JMP_NEXT,     '0);
            5'd5:    w = cw(OP_FIX,        DST_ACCEL, DIV_100,  JMP_NEXT,     '0);
            // gyro normalise
            5'd6:    w = cw(OP_MUL_GYRO,   DST_RATE,  DIV_100,  JMP_NEXT,     '0);
            5'd7:    w = cw(OP_RECIP,      DST_RATE,  DIV_100,  JMP_NEXT,     '0);
            5'd8:    w = cw(OP_QEST,       DST_RATE,  DIV_100,  JMP_NEXT,     '0);
            5'd9:    w = cw(OP_REM,        DST_RATE,  DIV_100,  JMP_NEXT,     '0);
            5'd10:   w = cw(OP_FIX,        DST_RATE,  DIV_100,  JMP_NEXT,     '0);
            // accelerometer feedback into the accumulator
            5'd11:   w = cw(OP_MUL_ERR,    DST_FB,    DIV_1000, JMP_NEXT,     '0);
            5'd12:   w = cw(OP_RECIP,      DST_FB,    DIV_1000, JMP_NEXT,     '0);
            5'd13:   w = cw(OP_QEST,       DST_FB,    DIV_1000, JMP_NEXT,     '0);
            5'd14:   w = cw(OP_REM,        DST_FB,    DIV_1000, JMP_NEXT,     '0);
            5'd15:   w = cw(OP_FIX,        DST_FB,    DIV_1000, JMP_NEXT,     '0);
            // PD drive
            5'd16:   w = cw(OP_MUL_ANG_P,  DST_PD,    DIV_100,  JMP_NEXT,     '0);
            5'd17:   w = cw(OP_SUM_SET,    DST_PD,    DIV_100,  JMP_NEXT,     '0);
            5'd18:   w = cw(OP_MUL_RATE_D, DST_PD,    DIV_100,  JMP_NEXT,     '0);
            5'd19:   w = cw(OP_SUM_ADD,    DST_PD,    DIV_100,  JMP_NEXT,     '0);
            5'd20:   w = cw(OP_SUM_ABS,    DST_PD,    DIV_100,  JMP_NEXT,     '0);
            5'd21:   w = cw(OP_RECIP,      DST_PD,    DIV_100,  JMP_NEXT,     '0);
            5'd22:   w = cw(OP_QEST,       DST_PD,    DIV_100,  JMP_NEXT,     '0);
            5'd23:   w = cw(OP_REM,        DST_PD,    DIV_100,  JMP_NEXT,     '0);
            5'd24:   w = cw(OP_FIX,        DST_PD,    DIV_100,  JMP_NEXT,     '0);
            5'd25:   w = cw(OP_CLAMP,      DST_PD,    DIV_100,  JMP_NEXT,     '0);
            5'd26:   w = cw(OP_DRIVE,      DST_PD,    DIV_100,  JMP_NEXT,     '0);
            5'd27:   w = cw(OP_OUT,        DST_PD,    DIV_100,  JMP_WAIT_OUT, '0);
            default: w = cw(OP_NOP,        DST_ACCEL, DIV_100,  JMP_GOTO,     '0);
        endcase
        return w;
    endfunction

endpackage

@@ rtl/tilt_complementary_filter_pd.sv @@
// Tilt complementary filter with PD drive: 28-step microcoded sequence per sample.
// A new sample is taken only at the load step, after the last one has run every step;
// the single shared 32x32 multiplier and the divide steps serve one sample at a time.
// A result still waiting when the next is ready holds the output step.
// Reset (aresetn low, synchronous): step counter to the load step, accumulator
// cleared, output invalid, configuration registers to their default values.
module tilt_complementary_filter_pd (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [11:0] accel_sample, [23:12] gyro_sample, [39:24] speed_correction
    input  logic [tcfpd_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] tilt_angle, [31:16] tilt_rate, [47:32] motor_drive
    output logic [tcfpd_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcfpd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tcfpd_pkg::*;

    cfg_t              cfg;
    ctrl_t             ctrl;
    stat_t             stat;
    logic              in_fire;
    logic              out_busy;
    logic [DATA_W-1:0] tilt_angle;
    logic [DATA_W-1:0] tilt_rate;
    logic [DATA_W-1:0] motor_drive;

    assign s_tready      = (ctrl.op == OP_LOAD);
    assign in_fire       = s_tvalid && s_tready;
    assign stat.in_valid = s_tvalid;
    assign stat.out_busy = out_busy;

    tcfpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcfpd_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    tcfpd_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .ctrl             (ctrl),
        .in_fire          (in_fire),
        .accel_sample     (s_tdata[SAMPLE_BITS-1:0]),
        .gyro_sample      (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .speed_correction (s_tdata[S_FIELDS_W-1:2*SAMPLE_BITS]),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .out_busy         (out_busy),
        .tilt_angle       (tilt_angle),
        .tilt_rate        (tilt_rate),
        .motor_drive      (motor_drive)
    );

    assign m_tdata = M_TDATA_W'({motor_drive, tilt_rate, tilt_angle});

endmodule

@@ rtl/tcfpd_cfg.sv @@
// Configuration register file of the tilt filter.
// Depends on tcfpd_pkg for the register layout and index codes.
module tcfpd_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcfpd_pkg::CFG_DATA_W-1:0] cfg_data,
    output tcfpd_pkg::cfg_t                  cfg
);
    import tcfpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_ACCEL_ZERO:  cfg_next.accel_zero  = cfg_data[SAMPLE_BITS-1:0];
                REG_GYRO_ZERO:   cfg_next.gyro_zero   = cfg_data[SAMPLE_BITS-1:0];
                REG_ACCEL_SCALE: cfg_next.accel_scale = cfg_data[GAIN_W-1:0];
                REG_GYRO_SCALE:  cfg_next.gyro_scale  = cfg_data[GAIN_W-1:0];
                REG_CORR_GAIN:   cfg_next.corr_gain   = cfg_data[GAIN_W-1:0];
                REG_P_GAIN:      cfg_next.p_gain      = cfg_data[GAIN_W-1:0];
                REG_D_GAIN:      cfg_next.d_gain      = cfg_data[GAIN_W-1:0];
                REG_DRIVE_LIMIT: cfg_next.drive_limit = cfg_data[LIMIT_W-1:0];
                default:         cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/tcfpd_seq.sv @@
// Microcode sequencer: step counter over the control store in tcfpd_pkg.
// Includes the assertion macros header.
`include "tilt_complementary_filter_pd_macros.svh"

module tcfpd_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  tcfpd_pkg::stat_t stat,
    output tcfpd_pkg::ctrl_t ctrl
);
    import tcfpd_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;

    assign ctrl = ucode(pc_reg);

    always_comb begin
        pc_next = pc_reg;
        case (ctrl.jmp)
            JMP_NEXT:     pc_next = pc_reg + PC_W'(1);
            JMP_WAIT_IN:  if (stat.in_valid) pc_next = pc_reg + PC_W'(1);
            JMP_WAIT_OUT: if (!stat.out_busy) pc_next = ctrl.target;
            JMP_GOTO:     pc_next = ctrl.target;
            default:      pc_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

    `TCFPD_ASSERT(a_pc_range, pc_reg < PC_W'(UCODE_LEN))
    `TCFPD_ASSERT_NEXT(a_load_advance, ctrl.op == OP_LOAD && stat.in_valid, pc_reg == PC_W'(1))
    `TCFPD_ASSERT_NEXT(a_out_hold, ctrl.jmp == JMP_WAIT_OUT && stat.out_busy, $stable(pc_reg))
    `TCFPD_ASSERT_NEXT(a_out_wrap, ctrl.jmp == JMP_WAIT_OUT && !stat.out_busy, pc_reg == '0)

endmodule

@@ rtl/tcfpd_dp.sv @@
// Datapath of the tilt filter: one shared 32x32 multiplier, reciprocal divide
// steps, accumulator and output register. Driven by control words from tcfpd_pkg.
module tcfpd_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tcfpd_pkg::cfg_t                   cfg,
    input  tcfpd_pkg::ctrl_t                  ctrl,
    input  logic                              in_fire,
    input  logic [tcfpd_pkg::SAMPLE_BITS-1:0] accel_sample,
    input  logic [tcfpd_pkg::SAMPLE_BITS-1:0] gyro_sample,
    input  logic [tcfpd_pkg::DATA_W-1:0]      speed_correction,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic                              out_busy,
    output logic [tcfpd_pkg::DATA_W-1:0]      tilt_angle,
    output logic [tcfpd_pkg::DATA_W-1:0]      tilt_rate,
    output logic [tcfpd_pkg::DATA_W-1:0]      motor_drive
);
    import tcfpd_pkg::*;

    logic [ACC_W-1:0]       acc_reg;
    logic [SAMPLE_BITS-1:0] as_reg;
    logic [SAMPLE_BITS-1:0] gs_reg;
    logic [DATA_W-1:0]      corr_reg;
    logic [DATA_W-1:0]      ang_reg;
    logic [DATA_W-1:0]      accel_reg;
    logic [DATA_W-1:0]      rate_reg;
    logic [63:0]            prod_reg;
    logic [31:0]            mag_reg;
    logic                   neg_reg;
    logic [31:0]            quo_reg;
    logic [REM_W-1:0]       rem_reg;
    logic signed [33:0]     sum_reg;
    logic signed [32:0]     pd_reg;
    logic [DATA_W-1:0]      pdc_reg;
    logic [DATA_W-1:0]      drv_reg;

    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [DATA_W-1:0]      out_angle_reg;
    logic [DATA_W-1:0]      out_rate_reg;
    logic [DATA_W-1:0]      out_drive_reg;

    logic signed [DELTA_W-1:0] delta_a;
    logic signed [DELTA_W-1:0] delta_g;
    logic signed [DATA_W:0]    err;
    logic signed [33:0]        abs_src;
    logic [33:0]               abs_val;
    logic [31:0]               mul_a;
    logic [31:0]               mul_b;
    logic [63:0]               mul_p;
    logic signed [33:0]        prod_s;
    logic [REM_W-1:0]          c_val;
    logic [31:0]               q_fix;
    logic signed [32:0]        sres;
    logic signed [32:0]        lim_pos;
    logic signed [32:0]        lim_neg;
    logic [DATA_W-1:0]         pdc_next;
    logic signed [DATA_W:0]    diff;
    logic [DATA_W-1:0]         drv_next;

    assign delta_a = $signed({1'b0, as_reg}) - $signed({1'b0, cfg.accel_zero});
    assign delta_g = $signed({1'b0, gs_reg}) - $signed({1'b0, cfg.gyro_zero});
    assign err     = $signed({accel_reg[DATA_W-1], accel_reg})
                   - $signed({ang_reg[DATA_W-1], ang_reg});

    // one magnitude unit; every operand that reaches it stays below 2**32
    always_comb begin
        case (ctrl.op)
            OP_MUL_ACCEL:  abs_src = {{(34-DELTA_W){delta_a[DELTA_W-1]}}, delta_a};
            OP_MUL_GYRO:   abs_src = {{(34-DELTA_W){delta_g[DELTA_W-1]}}, delta_g};
            OP_MUL_ERR:    abs_src = {{(33-DATA_W){err[DATA_W]}}, err};
            OP_MUL_ANG_P:  abs_src = {{(34-DATA_W){ang_reg[DATA_W-1]}}, ang_reg};
            OP_MUL_RATE_D: abs_src = {{(34-DATA_W){rate_reg[DATA_W-1]}}, rate_reg};
            OP_SUM_ABS:    abs_src = sum_reg;
            default:       abs_src = '0;
        endcase
    end

    assign abs_val = abs_src[33] ? -abs_src : abs_src;

    always_comb begin
        mul_a = abs_val[31:0];
        case (ctrl.op)
            OP_MUL_ACCEL:  mul_b = 32'(cfg.accel_scale);
            OP_MUL_GYRO:   mul_b = 32'(cfg.gyro_scale);
            OP_MUL_ERR:    mul_b = 32'(cfg.corr_gain);
            OP_MUL_ANG_P:  mul_b = 32'(cfg.p_gain);
            OP_MUL_RATE_D: mul_b = 32'(cfg.d_gain);
            OP_RECIP: begin
                mul_a = prod_reg[31:0];
                mul_b = (ctrl.dv == DIV_1000) ? DIV1000_RECIP : DIV100_RECIP;
            end
            default:       mul_b = '0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign prod_s = neg_reg ? -$signed({2'b00, prod_reg[31:0]})
                            : $signed({2'b00, prod_reg[31:0]});

    // quotient estimate is exact or one low; the remainder decides
    assign c_val = div_const(ctrl.dv);
    assign q_fix = quo_reg + 32'(rem_reg >= c_val);
    assign sres  = neg_reg ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});

    assign lim_pos = $signed({{(33-LIMIT_W){1'b0}}, cfg.drive_limit});
    assign lim_neg = -lim_pos;

    always_comb begin
        if (pd_reg > lim_pos) begin
            pdc_next = lim_pos[DATA_W-1:0];
        end else if (pd_reg < lim_neg) begin
            pdc_next = lim_neg[DATA_W-1:0];
        end else begin
            pdc_next = pd_reg[DATA_W-1:0];
        end
    end

    assign diff = $signed({pdc_reg[DATA_W-1], pdc_reg})
                - $signed({corr_reg[DATA_W-1], corr_reg});

    always_comb begin
        if (diff > DRV_MAX) begin
            drv_next = DRV_MAX[DATA_W-1:0];
        end else if (diff < DRV_MIN) begin
            drv_next = DRV_MIN[DATA_W-1:0];
        end else begin
            drv_next = diff[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctrl.op == OP_FIX && ctrl.dst == DST_FB) begin
            acc_reg <= acc_reg + {{(ACC_W-DATA_W){rate_reg[DATA_W-1]}}, rate_reg}
                     + sres[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            as_reg   <= accel_sample;
            gs_reg   <= gyro_sample;
            corr_reg <= speed_correction;
            ang_reg  <= acc_reg[ANGLE_SHIFT+DATA_W-1:ANGLE_SHIFT];
        end
        case (ctrl.op)
            OP_MUL_ACCEL, OP_MUL_GYRO, OP_MUL_ERR, OP_MUL_ANG_P, OP_MUL_RATE_D: begin
                prod_reg <= mul_p;
                neg_reg  <= abs_src[33];
            end
            OP_SUM_SET: sum_reg <= prod_s;
            OP_SUM_ADD: sum_reg <= sum_reg + prod_s;
            OP_SUM_ABS: begin
                prod_reg <= {32'b0, abs_val[31:0]};
                neg_reg  <= abs_src[33];
            end
            OP_RECIP: begin
                mag_reg  <= prod_reg[31:0];
                prod_reg <= mul_p;
            end
            OP_QEST: begin
                if (ctrl.dv == DIV_1000) begin
                    quo_reg <= 32'(prod_reg >> DIV1000_SHIFT);
                end else begin
                    quo_reg <= 32'(prod_reg >> DIV100_SHIFT);
                end
            end
            OP_REM: rem_reg <= REM_W'(mag_reg - quo_reg * 32'(c_val));
            OP_FIX: begin
                case (ctrl.dst)
                    DST_ACCEL: accel_reg <= sres[DATA_W-1:0];
                    DST_RATE:  rate_reg  <= sres[DATA_W-1:0];
                    DST_PD:    pd_reg    <= sres;
                    default:   ;
                endcase
            end
            OP_CLAMP: pdc_reg <= pdc_next;
            OP_DRIVE: drv_reg <= drv_next;
            default:  ;
        endcase
    end

    // output register: refill as soon as the previous beat is taken
    assign out_busy = m_tvalid_reg && !m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (ctrl.op == OP_OUT && !out_busy) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.op == OP_OUT && !out_busy) begin
            out_angle_reg <= ang_reg;
            out_rate_reg  <= rate_reg;
            out_drive_reg <= drv_reg;
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign tilt_angle  = out_angle_reg;
    assign tilt_rate   = out_rate_reg;
    assign motor_drive = out_drive_reg;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for tilt_complementary_filter_pd: drives sensor beats and register writes,
// predicts angle, rate and drive per beat, and checks every result beat in order.
// Depends on tcfpd_pkg and the top-level RTL only.
module tb_top;
    import tcfpd_pkg::*;

    localparam int NUM_REGS     = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_TAIL  = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS  = 169;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [15:0] tilt_angle;
        logic [15:0] tilt_rate;
        logic [15:0] motor_drive;
    } tilt_result_t;

    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE} ready_style_t;

    // Bit-true model of the filter plus the queue of results still owed by the block
    class tilt_drive_model;
        logic [11:0] accel_zero  = 12'd2048;
        logic [11:0] gyro_zero   = 12'd2048;
        logic [15:0] accel_scale = 16'd100;
        logic [15:0] gyro_scale  = 16'd100;
        logic [15:0] corr_gain   = '0;
        logic [15:0] p_gain      = '0;
        logic [15:0] d_gain      = '0;
        logic [14:0] drive_limit = 15'd32767;
        logic [31:0] angle_acc   = '0;
        tilt_result_t pending_drives[$];
        int failures = 0;

        function void write_reg(logic [3:0] idx, logic [15:0] data);
            case (idx)
                REG_ACCEL_ZERO:  accel_zero  = data[11:0];
                REG_GYRO_ZERO:   gyro_zero   = data[11:0];
                REG_ACCEL_SCALE: accel_scale = data;
                REG_GYRO_SCALE:  gyro_scale  = data;
                REG_CORR_GAIN:   corr_gain   = data;
                REG_P_GAIN:      p_gain      = data;
                REG_D_GAIN:      d_gain      = data;
                REG_DRIVE_LIMIT: drive_limit = data[14:0];
                default: ;
            endcase
        endfunction

        // Remove offset, apply gain over 100, keep the low 16 bits
        function logic signed [15:0] scaled(logic [11:0] raw, logic [11:0] zero,
                                            logic [15:0] gain);
            longint v;
            v = (longint'(raw) - longint'(zero)) * longint'(gain) / 100;
            return v[15:0];
        endfunction

        function void take_sample(logic [11:0] a_raw, logic [11:0] g_raw, logic [15:0] corr);
            tilt_result_t want;
            logic signed [15:0] accel, rate, angle, corr_s;
            logic signed [31:0] shifted;
            longint fb, pd, drive, lim;
            accel   = scaled(a_raw, accel_zero, accel_scale);
            rate    = scaled(g_raw, gyro_zero, gyro_scale);
            corr_s  = corr;
            shifted = $signed(angle_acc) >>> 5;
            angle   = shifted[15:0];
            fb = (longint'(accel) - longint'(angle)) * longint'(corr_gain) / 1000;
            angle_acc = angle_acc + 32'(longint'(rate) + fb);
            pd = (longint'(angle) * longint'(p_gain) + longint'(rate) * longint'(d_gain)) / 100;
            lim = longint'(drive_limit);
            if (pd > lim) begin
                pd = lim;
            end else if (pd < -lim) begin
                pd = -lim;
            end
            drive = pd - longint'(corr_s);
            if (drive > 32767) begin
                drive = 32767;
            end else if (drive < -32768) begin
                drive = -32768;
            end
            want.tilt_angle  = angle;
            want.tilt_rate   = rate;
            want.motor_drive = drive[15:0];
            pending_drives.push_back(want);
        endfunction

        function void check_drive(logic [47:0] beat);
            tilt_result_t want;
            if (pending_drives.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result beat %h", beat);
                return;
            end
            want = pending_drives.pop_front();
            if (beat[15:0] !== want.tilt_angle || beat[31:16] !== want.tilt_rate ||
                beat[47:32] !== want.motor_drive) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("mismatch: angle %0d/%0d rate %0d/%0d drive %0d/%0d (exp/got)",
                             $signed(want.tilt_angle), $signed(beat[15:0]),
                             $signed(want.tilt_rate), $signed(beat[31:16]),
                             $signed(want.motor_drive), $signed(beat[47:32]));
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tilt_drive_model model = new();
    int burst_left;
    int idle_cycles;

    tilt_complementary_filter_pd i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Beats are taken at the rising edge, before the block updates its outputs
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                model.take_sample(s_tdata[11:0], s_tdata[23:12], s_tdata[39:24]);
            if (m_tvalid && m_tready)
                model.check_drive(m_tdata[47:0]);
            if (cfg_valid && cfg_ready)
                model.write_reg(cfg_index, cfg_data);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: switch between always ready, coin flips and long stalls
    initial begin
        ready_style_t style;
        int stretch;
        m_tready = 1'b1;
        forever begin
            stretch = $urandom_range(200, 20);
            style   = ready_style_t'($urandom_range(2, 0));
            repeat (stretch) begin
                @(negedge aclk);
                case (style)
                    RDY_ALWAYS: m_tready = 1'b1;
                    RDY_COIN:   m_tready = 1'($urandom_range(1, 0));
                    default:    m_tready = ($urandom_range(15, 0) == 0);
                endcase
            end
        end
    end

    task automatic cfg_write(logic [3:0] idx, logic [15:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Write every register, then one index past the map that must be ignored
    task automatic set_all(logic [15:0] az, logic [15:0] gz, logic [15:0] as_v,
                           logic [15:0] gs, logic [15:0] cg, logic [15:0] p,
                           logic [15:0] d, logic [15:0] lim);
        cfg_write(REG_ACCEL_ZERO, az);
        cfg_write(REG_GYRO_ZERO, gz);
        cfg_write(REG_ACCEL_SCALE, as_v);
        cfg_write(REG_GYRO_SCALE, gs);
        cfg_write(REG_CORR_GAIN, cg);
        cfg_write(REG_P_GAIN, p);
        cfg_write(REG_D_GAIN, d);
        cfg_write(REG_DRIVE_LIMIT, lim);
        cfg_write(4'($urandom_range(15, NUM_REGS)), 16'($urandom));
    endtask

    // Called at a falling edge; returns at one after the beat is taken and any idle gap
    task automatic send_sample(logic [11:0] a, logic [11:0] g, logic [15:0] c);
        s_tdata  = S_TDATA_W'({c, g, a});
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(12, 1)) @(negedge aclk);
            burst_left = $urandom_range(20, 0);
        end else begin
            burst_left--;
        end
    endtask

    // Drop valid and let every owed result come back before touching registers
    task automatic drain();
        s_tvalid = 1'b0;
        while (model.pending_drives.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [11:0] near_zero(logic [11:0] zero, int span);
        int v;
        v = int'(zero) + int'($urandom_range(2 * span, 0)) - span;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    function automatic logic [15:0] pick_gain(int typical);
        case ($urandom_range(7, 0))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(typical, 0));
        endcase
    endfunction

    task automatic send_random(int count);
        int pick;
        logic [11:0] a, g;
        logic [15:0] c;
        repeat (count) begin
            pick = $urandom_range(9, 0);
            if (pick < 4) begin
                a = 12'($urandom);
                g = 12'($urandom);
                c = 16'($urandom);
            end else if (pick < 8) begin
                // small excursions keep the filter off the rails
                a = near_zero(model.accel_zero, 300);
                g = near_zero(model.gyro_zero, 60);
                c = 16'(int'($urandom_range(2000, 0)) - 1000);
            end else begin
                a = $urandom_range(1, 0) ? 12'hFFF : 12'h000;
                g = $urandom_range(1, 0) ? 12'hFFF : 12'h000;
                case ($urandom_range(3, 0))
                    0:       c = 16'h8000;
                    1:       c = 16'h7FFF;
                    2:       c = 16'h0000;
                    default: c = 16'($urandom);
                endcase
            end
            send_sample(a, g, c);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        burst_left = $urandom_range(20, 0);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: zero gains, so drive is the negated correction, saturated
        send_sample(12'd0, 12'd0, 16'h0000);
        send_sample(12'hFFF, 12'hFFF, 16'h7FFF);
        send_sample(12'd2048, 12'd2048, 16'h8000);
        send_sample(12'hFFF, 12'd0, 16'h0000);
        send_sample(12'd0, 12'hFFF, 16'h0001);
        drain();

        set_all(16'd2048, 16'd2048, 16'd100, 16'd100, 16'd20, 16'd500, 16'd50, 16'd10000);
        send_sample(12'hFFF, 12'd2048, 16'h0000);
        send_sample(12'hFFF, 12'd2048, 16'h0000);
        send_sample(12'd2048, 12'hFFF, 16'h0000);
        send_sample(12'd2048, 12'hFFF, 16'hF000);
        send_sample(12'd0, 12'd0, 16'h0FFF);
        drain();

        // full-scale gains: scaled values and accumulator wrap, top bits masked off
        set_all(16'hF000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF);
        send_sample(12'hFFF, 12'd0, 16'h8000);
        send_sample(12'd0, 12'hFFF, 16'h7FFF);
        send_sample(12'hFFF, 12'hFFF, 16'h0000);
        send_sample(12'h800, 12'h000, 16'h8000);
        send_sample(12'hFFF, 12'h000, 16'h7FFF);
        send_sample(12'h001, 12'hFFE, 16'h1234);
        drain();

        // zero gains and zero limit force the drive to the negated correction
        set_all(16'h0FFF, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
        send_sample(12'd0, 12'd0, 16'h8000);
        send_sample(12'hFFF, 12'hFFF, 16'h7FFF);
        send_sample(12'h5A5, 12'hA5A, 16'h0000);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_all(16'($urandom), 16'($urandom), pick_gain(400), pick_gain(400),
                    pick_gain(100), pick_gain(3000), pick_gain(3000),
                    $urandom_range(3, 0) == 0 ? 16'($urandom) : 16'($urandom_range(20000, 0)));
            send_random(PHASE_ITEMS);
            drain();
        end

        repeat (SETTLE_TAIL) @(posedge aclk);
        if (model.failures == 0 && model.pending_drives.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tcfpd_pkg.sv
rtl/tcfpd_cfg.sv
rtl/tcfpd_seq.sv
rtl/tcfpd_dp.sv
rtl/tilt_complementary_filter_pd.sv
dv/tb_top.sv
